### sv/dwmd_pkg.sv
// shared constants of the distinct window marker detector
`default_nettype none
package dwmd_pkg;

   localparam int MAX_WINDOW_DEFAULT = 16;

   localparam int BYTE_W  = 8;
   localparam int POS_W   = 16;
   localparam int WIN_W   = 5;
   localparam int DATA_W  = 32;
   localparam int ADDR_W  = 3;

   localparam logic [WIN_W-1:0] WINDOW_RESET = 5'd4;
   localparam logic [POS_W-1:0] POS_MAX      = 16'hFFFF;

   // register index, taken from paddr[2]
   localparam logic REG_WINDOW_LENGTH = 1'b0;

endpackage
`default_nettype wire

### sv/dwmd_csr.sv
// configuration register block for the window length
`default_nettype none
module dwmd_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [dwmd_pkg::ADDR_W-1:0]    paddr,
   input  wire logic [dwmd_pkg::DATA_W-1:0]    pwdata,
   output logic      [dwmd_pkg::DATA_W-1:0]    prdata,
   output logic                                pready,
   output logic      [dwmd_pkg::WIN_W-1:0]     window_length
);

   logic [dwmd_pkg::WIN_W-1:0] window_ff;
   logic [dwmd_pkg::WIN_W-1:0] window_in;
   logic                       hit;

   assign hit    = (paddr[2] == dwmd_pkg::REG_WINDOW_LENGTH);
   assign pready = 1'b1;

   always_comb begin
      window_in = window_ff;
      if (psel && penable && pwrite && hit) begin
         window_in = pwdata[dwmd_pkg::WIN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= dwmd_pkg::WINDOW_RESET;
      end else begin
         window_ff <= window_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (hit) begin
         prdata = {{(dwmd_pkg::DATA_W-dwmd_pkg::WIN_W){1'b0}}, window_ff};
      end
   end

   assign window_length = window_ff;

endmodule
`default_nettype wire

### sv/distinct_window_marker_detector.sv
// top level of the distinct window marker detector
// request channel: one stream byte plus stream_start per request, taken when
//   req_valid is high and req_stall is low. stream_start clears the count, the
//   distinct run and the done flag before that byte is handled.
// response channel: one response per request, in order: marker_found, the
//   saturating byte count and finished. it sits in an output register, held
//   while rsp_stall is high; a new request is taken while it waits.
// csr port: window_length at byte address 0, written in the access phase.
// operation: recent bytes sit in a MAX_WINDOW entry ring memory with a
//   registered read. a run register holds how many trailing bytes are pairwise
//   distinct; each new byte is compared against the earlier bytes of that run,
//   one memory read per cycle, nearest first, stopping at the first equal byte.
// timing: a byte goes through IDLE, one SCAN state per earlier byte scanned and
//   EMIT, which waits while the output register is held; the scan is serial, set
//   by the single read port. bytes after the marker skip SCAN. the response leaves
//   the output register the cycle after it is loaded if rsp_stall is low.
// reset: synchronous, active high. count, run and done clear, window_length
//   goes to 4. the ring memory needs no clearing, only bytes of the run are read
`default_nettype none
module distinct_window_marker_detector #(
   parameter int MAX_WINDOW = dwmd_pkg::MAX_WINDOW_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [dwmd_pkg::BYTE_W-1:0]    req_byte_value,
   input  wire logic                           req_stream_start,
   // response channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_marker_found,
   output logic      [dwmd_pkg::POS_W-1:0]     rsp_position,
   output logic                                rsp_finished,
   // configuration port
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [dwmd_pkg::ADDR_W-1:0]    csr_paddr,
   input  wire logic [dwmd_pkg::DATA_W-1:0]    csr_pwdata,
   output logic      [dwmd_pkg::DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);

   localparam int AW    = $clog2(MAX_WINDOW);
   localparam int RUN_W = $clog2(MAX_WINDOW + 1);
   localparam int CW    = (RUN_W > dwmd_pkg::WIN_W) ? RUN_W : dwmd_pkg::WIN_W;

   localparam logic [RUN_W-1:0] RUN_MAX  = RUN_W'(MAX_WINDOW);
   localparam logic [AW-1:0]    SCAN_MAX = AW'(MAX_WINDOW - 1);
   localparam logic [AW-1:0]    ADDR_TOP = AW'(MAX_WINDOW - 1);

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [dwmd_pkg::WIN_W-1:0] window_length;

   dwmd_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (csr_psel),
      .penable       (csr_penable),
      .pwrite        (csr_pwrite),
      .paddr         (csr_paddr),
      .pwdata        (csr_pwdata),
      .prdata        (csr_prdata),
      .pready        (csr_pready),
      .window_length (window_length)
   );

   // ring address that lies offset entries before base
   function automatic logic [AW-1:0] ring_back(input logic [AW-1:0] base,
                                               input logic [AW-1:0] offset);
      logic [AW:0] wide;
      if (base >= offset) begin
         wide = {1'b0, base} - {1'b0, offset};
      end else begin
         wide = {1'b0, base} + (AW+1)'(MAX_WINDOW) - {1'b0, offset};
      end
      return wide[AW-1:0];
   endfunction

   // control state
   logic [1:0]                  state_ff, state_in;
   logic [dwmd_pkg::POS_W-1:0]  count_ff, count_in;
   logic                        done_ff, done_in;
   logic [RUN_W-1:0]            run_ff, run_in;
   logic [AW-1:0]               wp_ff, wp_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // per request working registers
   logic [dwmd_pkg::BYTE_W-1:0] byte_ff, byte_in;
   logic [AW-1:0]               base_ff, base_in;
   logic [AW-1:0]               dist_ff, dist_in;
   logic [AW-1:0]               scan_len_ff, scan_len_in;
   logic [RUN_W-1:0]            run_new_ff, run_new_in;
   logic                        hold_ff, hold_in;

   // response payload
   logic                        rsp_found_ff, rsp_found_in;
   logic [dwmd_pkg::POS_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic                        rsp_fin_ff, rsp_fin_in;

   // ring memory of recent bytes
   logic [dwmd_pkg::BYTE_W-1:0] ring_mem [MAX_WINDOW];
   logic [dwmd_pkg::BYTE_W-1:0] rd_data_ff;
   logic                        wr_en, rd_en;
   logic [AW-1:0]               wr_addr, rd_addr;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= byte_in;
      end
      if (rd_en) begin
         rd_data_ff <= ring_mem[rd_addr];
      end
   end

   // effective window: zero acts as one, oversize clamps to MAX_WINDOW
   logic [CW-1:0]    win_ext;
   logic [RUN_W-1:0] win_eff;
   always_comb begin
      win_ext = CW'(window_length);
      if (window_length == '0) begin
         win_eff = RUN_W'(1);
      end else if (win_ext > CW'(MAX_WINDOW)) begin
         win_eff = RUN_MAX;
      end else begin
         win_eff = win_ext[RUN_W-1:0];
      end
   end

   logic                        req_accept;
   logic                        slot_free;
   logic [dwmd_pkg::POS_W-1:0]  count_base;
   logic                        done_base;
   logic [RUN_W-1:0]            run_base;
   logic [RUN_W-1:0]            run_grow_base, run_grow_cur;
   logic [AW-1:0]               scan_len_acc;
   logic                        found;

   assign req_accept = req_valid && (state_ff == ST_IDLE);
   assign req_stall  = (state_ff != ST_IDLE);
   assign slot_free  = !rsp_valid_ff || !rsp_stall;

   // stream start clears before the byte is handled
   assign count_base = req_stream_start ? '0 : count_ff;
   assign done_base  = req_stream_start ? 1'b0 : done_ff;
   assign run_base   = req_stream_start ? '0 : run_ff;

   // run grows by one when no earlier byte of the run matches
   assign run_grow_base = (run_base == RUN_MAX) ? RUN_MAX : run_base + RUN_W'(1);
   assign run_grow_cur  = (run_ff == RUN_MAX) ? RUN_MAX : run_ff + RUN_W'(1);

   // only earlier bytes of the run can shorten it
   assign scan_len_acc = (run_base >= RUN_W'(MAX_WINDOW - 1)) ? SCAN_MAX
                                                              : run_base[AW-1:0];

   assign found = !hold_ff && (run_new_ff >= win_eff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      done_in      = done_ff;
      run_in       = run_ff;
      wp_in        = wp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      byte_in      = byte_ff;
      base_in      = base_ff;
      dist_in      = dist_ff;
      scan_len_in  = scan_len_ff;
      run_new_in   = run_new_ff;
      hold_in      = hold_ff;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_fin_in   = rsp_fin_ff;
      wr_en        = 1'b0;
      wr_addr      = wp_ff;
      rd_en        = 1'b0;
      rd_addr      = ring_back(base_ff, dist_ff + AW'(1));

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               byte_in  = req_byte_value;
               count_in = count_base;
               done_in  = done_base;
               run_in   = run_base;
               if (done_base) begin
                  // marker already found: byte ignored
                  hold_in    = 1'b1;
                  run_new_in = run_base;
                  state_in   = ST_EMIT;
               end else begin
                  hold_in     = 1'b0;
                  count_in    = (count_base == dwmd_pkg::POS_MAX) ? count_base
                                                                  : count_base + 16'd1;
                  wr_en       = 1'b1;
                  base_in     = wp_ff;
                  wp_in       = (wp_ff == ADDR_TOP) ? '0 : wp_ff + AW'(1);
                  scan_len_in = scan_len_acc;
                  dist_in     = AW'(1);
                  if (scan_len_acc == '0) begin
                     run_new_in = run_grow_base;
                     state_in   = ST_EMIT;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = ring_back(wp_ff, AW'(1));
                     state_in = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (rd_data_ff == byte_ff) begin
               // nearest repeat bounds the distinct run
               run_new_in = RUN_W'(dist_ff);
               state_in   = ST_EMIT;
            end else if (dist_ff == scan_len_ff) begin
               run_new_in = run_grow_cur;
               state_in   = ST_EMIT;
            end else begin
               rd_en   = 1'b1;
               dist_in = dist_ff + AW'(1);
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found;
               rsp_pos_in   = count_ff;
               rsp_fin_in   = done_ff || found;
               done_in      = done_ff || found;
               run_in       = run_new_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         done_ff      <= 1'b0;
         run_ff       <= '0;
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         done_ff      <= done_in;
         run_ff       <= run_in;
         wp_ff        <= wp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      base_ff      <= base_in;
      dist_ff      <= dist_in;
      scan_len_ff  <= scan_len_in;
      run_new_ff   <= run_new_in;
      hold_ff      <= hold_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_fin_ff   <= rsp_fin_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_marker_found = rsp_found_ff;
   assign rsp_position     = rsp_pos_ff;
   assign rsp_finished     = rsp_fin_ff;

endmodule
`default_nettype wire
